// ----- hdl/mbet_pkg.sv -----
// shared types, constants and helpers for the escape-time pixel evaluator
// no dependencies; imported by every module of the block

package mbet_pkg;

    localparam int COORD_BITS = 12;
    localparam int ITER_BITS  = 10;
    localparam int FRAC_BITS  = 28;
    localparam int WORD_BITS  = 32;
    localparam int GREY_BITS  = 8;
    localparam int CFG_IDX_BITS = 3;

    localparam int QUEUE_DEPTH_DEF = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_RE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_IM     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ZOOM          = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_COLUMN = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_ROW    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ITER_LIMIT    = 3'd5;

    localparam logic signed [WORD_BITS-1:0] ORIGIN_RE_RESET = 32'sd0;
    localparam logic signed [WORD_BITS-1:0] ORIGIN_IM_RESET = 32'sd0;
    localparam logic signed [WORD_BITS-1:0] ZOOM_RESET      = 32'sd805306;
    localparam logic [COORD_BITS-1:0] CENTER_COLUMN_RESET  = COORD_BITS'(960);
    localparam logic [COORD_BITS-1:0] CENTER_ROW_RESET     = COORD_BITS'(540);
    localparam logic [ITER_BITS-1:0]  ITER_LIMIT_RESET     = ITER_BITS'(255 * 3);

    localparam logic signed [63:0] WORD_MAX  = 64'sd2147483647;
    localparam logic signed [63:0] WORD_MIN  = -64'sd2147483648;
    // escape when |z|^2 is strictly above 4.0
    localparam logic signed [63:0] ESC_LIMIT = 64'sd4 <<< FRAC_BITS;
    localparam logic [8:0] GREY_MOD = 9'd255;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_column;
        logic [COORD_BITS-1:0] pixel_row;
    } t_pixel;

    typedef struct packed {
        logic [ITER_BITS-1:0] escape_count;
        logic [GREY_BITS-1:0] grey_level;
    } t_result;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] origin_re;
        logic signed [WORD_BITS-1:0] origin_im;
        logic signed [WORD_BITS-1:0] zoom;
        logic [COORD_BITS-1:0]       center_column;
        logic [COORD_BITS-1:0]       center_row;
        logic [ITER_BITS-1:0]        iter_limit;
    } t_cfg;

    // mapped complex point handed from front to back
    typedef struct packed {
        logic signed [WORD_BITS-1:0] re;
        logic signed [WORD_BITS-1:0] im;
    } t_point;

    function automatic logic signed [WORD_BITS-1:0] sat_word(logic signed [63:0] v);
        if (v > WORD_MAX) begin
            return WORD_MAX[WORD_BITS-1:0];
        end else if (v < WORD_MIN) begin
            return WORD_MIN[WORD_BITS-1:0];
        end
        return signed'(v[WORD_BITS-1:0]);
    endfunction

    // count mod 255 by folding bytes; the fold handles 16 bits, the argument is ITER_BITS wide
    function automatic logic [GREY_BITS-1:0] grey_of(logic [ITER_BITS-1:0] c);
        logic [15:0] w;
        logic [8:0]  s1;
        logic [8:0]  s2;
        w  = 16'(c);
        s1 = {1'b0, w[7:0]} + {1'b0, w[15:8]};
        s2 = {1'b0, s1[7:0]} + 9'(s1[8]);
        if (s2 >= GREY_MOD) begin
            s2 = s2 - GREY_MOD;
        end
        return s2[GREY_BITS-1:0];
    endfunction

endpackage

// ----- hdl/mandelbrot_escape_time_pixel.sv -----
// escape-time pixel evaluator: result gives the escape count and a grey level (count mod 255)
// the back end iterates one pixel at a time, a multiply phase then an add phase per z*z+c step
// the front maps the next pixels into a short queue while a pixel iterates
// reset (synchronous, active low) empties the queue and output, loads register defaults
// top level: configuration registers, uses mbet_pkg, mbet_front, mbet_queue, mbet_back

module mandelbrot_escape_time_pixel
    import mbet_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [WORD_BITS-1:0]    i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_pixel                  i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_result                 o_out_data
);

    t_cfg   r_cfg;
    logic   q_full;
    logic   q_valid;
    logic   push;
    logic   pop;
    t_point push_data;
    t_point q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_re     <= ORIGIN_RE_RESET;
            r_cfg.origin_im     <= ORIGIN_IM_RESET;
            r_cfg.zoom          <= ZOOM_RESET;
            r_cfg.center_column <= CENTER_COLUMN_RESET;
            r_cfg.center_row    <= CENTER_ROW_RESET;
            r_cfg.iter_limit    <= ITER_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ORIGIN_RE:     r_cfg.origin_re     <= signed'(i_cfg_data);
                CFG_ORIGIN_IM:     r_cfg.origin_im     <= signed'(i_cfg_data);
                CFG_ZOOM:          r_cfg.zoom          <= signed'(i_cfg_data);
                CFG_CENTER_COLUMN: r_cfg.center_column <= i_cfg_data[COORD_BITS-1:0];
                CFG_CENTER_ROW:    r_cfg.center_row    <= i_cfg_data[COORD_BITS-1:0];
                CFG_ITER_LIMIT:    r_cfg.iter_limit    <= i_cfg_data[ITER_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    mbet_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    mbet_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    mbet_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_iter_limit (r_cfg.iter_limit),
        .i_q_valid    (q_valid),
        .i_q_data     (q_data),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

// ----- hdl/mbet_front.sv -----
// front end: takes a pixel transaction and maps it to a complex point
// uses mbet_pkg; feeds mbet_queue

module mbet_front
    import mbet_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    input  t_pixel i_in_data,
    input  logic   i_q_full,
    output logic   o_push,
    output t_point o_push_data
);

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + WORD_BITS;

    logic                        r_s1_valid;
    logic signed [PROD_BITS-1:0] r_prod_re;
    logic signed [PROD_BITS-1:0] r_prod_im;

    logic signed [DIFF_BITS-1:0] diff_col;
    logic signed [DIFF_BITS-1:0] diff_row;
    logic                        accept;

    assign o_in_stall = r_s1_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_s1_valid && !i_q_full;

    assign diff_col = signed'({1'b0, i_in_data.pixel_column}) -
                      signed'({1'b0, i_cfg.center_column});
    assign diff_row = signed'({1'b0, i_in_data.pixel_row}) -
                      signed'({1'b0, i_cfg.center_row});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (o_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod_re <= diff_col * i_cfg.zoom;
            r_prod_im <= diff_row * i_cfg.zoom;
        end
    end

    // second half of the mapping: add view center and saturate
    assign o_push_data.re = sat_word(64'(r_prod_re) + 64'(i_cfg.origin_re));
    assign o_push_data.im = sat_word(64'(r_prod_im) + 64'(i_cfg.origin_im));

endmodule

// ----- hdl/mbet_queue.sv -----
// short fifo of mapped points between front and back
// uses mbet_pkg for the entry type

module mbet_queue
    import mbet_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_point i_push_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_point o_data
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);

    t_point              r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ----- hdl/mbet_back.sv -----
// back end: iterates z = z*z + c for one point and holds the result transaction
// uses mbet_pkg; pops points from mbet_queue

module mbet_back
    import mbet_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [ITER_BITS-1:0] i_iter_limit,
    input  logic                 i_q_valid,
    input  t_point               i_q_data,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_result              o_out_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_ADD  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    logic [ITER_BITS-1:0]        r_step;
    logic [ITER_BITS-1:0]        n_step;
    logic signed [WORD_BITS-1:0] r_z_re;
    logic signed [WORD_BITS-1:0] n_z_re;
    logic signed [WORD_BITS-1:0] r_z_im;
    logic signed [WORD_BITS-1:0] n_z_im;
    logic signed [WORD_BITS-1:0] r_c_re;
    logic signed [WORD_BITS-1:0] r_c_im;
    logic signed [63:0]          r_rr;
    logic signed [63:0]          r_ii;
    logic signed [63:0]          r_ri;
    logic                        r_out_valid;
    t_result                     r_out_data;

    logic signed [63:0] prod_rr;
    logic signed [63:0] prod_ii;
    logic signed [63:0] prod_ri;
    logic signed [63:0] mag;
    logic               escaped;
    logic               out_free;
    logic               load_out;

    assign prod_rr = r_z_re * r_z_re;
    assign prod_ii = r_z_im * r_z_im;
    assign prod_ri = r_z_re * r_z_im;

    // the squares of the current z double as the escape test of the last step
    assign mag     = r_rr + r_ii;
    assign escaped = (r_step != '0) && (mag > ESC_LIMIT);

    assign out_free = !r_out_valid || !i_out_stall;
    assign load_out = (r_state == S_DONE) && out_free;
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_z_re  = r_z_re;
        n_z_im  = r_z_im;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_MUL;
                    n_step  = '0;
                    n_z_re  = '0;
                    n_z_im  = '0;
                end
            end
            S_MUL: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                if (escaped || (r_step == i_iter_limit)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                    n_step  = r_step + 1'b1;
                    n_z_re  = sat_word(r_rr - r_ii + 64'(r_c_re));
                    n_z_im  = sat_word(r_ri + 64'(r_c_im));
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_z_re      <= '0;
            r_z_im      <= '0;
            r_c_re      <= '0;
            r_c_im      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_z_re  <= n_z_re;
            r_z_im  <= n_z_im;
            if (o_pop) begin
                r_c_re <= i_q_data.re;
                r_c_im <= i_q_data.im;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_rr <= prod_rr >>> FRAC_BITS;
            r_ii <= prod_ii >>> FRAC_BITS;
            r_ri <= prod_ri >>> (FRAC_BITS - 1);
        end
        if (load_out) begin
            r_out_data.escape_count <= r_step;
            r_out_data.grey_level   <= grey_of(r_step);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_add_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> ($past(r_state) == S_MUL))
        else $error("add phase without a preceding multiply phase");

    a_loop_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MUL) && ($past(r_state) == S_ADD)) |-> (r_step != '0))
        else $error("iteration repeated without advancing the step count");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> ($past(r_state) == S_DONE))
        else $error("result transaction appeared outside the done phase");

endmodule
